// ----- rtl/sfrt_pkg.sv -----
// Package with the types, codes and helper functions of the syscall filter rule table.
`default_nettype none
package sfrt_pkg;

    localparam int RULE_SLOTS_DEF = 16;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ACT_ALLOW = 3'd0;
    localparam logic [2:0] ACT_KILL  = 3'd1;
    localparam logic [2:0] ACT_TRAP  = 3'd2;
    localparam logic [2:0] ACT_ERRNO = 3'd3;
    localparam logic [2:0] ACT_LOG   = 3'd4;
    localparam logic [2:0] ACT_TRACE = 3'd5;

    localparam logic [1:0] V_ALLOW = 2'd0;
    localparam logic [1:0] V_DENY  = 2'd1;
    localparam logic [1:0] V_HALT  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [15:0] sys;
        logic        hit;
        logic [2:0]  act;
        logic [31:0] err;
    } t_probe;

    typedef struct packed {
        logic        en;
        logic [15:0] sys;
        logic [2:0]  act;
        logic [31:0] err;
    } t_wr;

    typedef struct packed {
        logic [1:0]  verdict;
        logic        errno_valid;
        logic [31:0] errno_value;
        logic        log_request;
        logic        add_status;
    } t_result;

    function automatic logic [1:0] f_rule_verdict(input logic [2:0] act);
        logic [1:0] v;
        case (act)
            ACT_ALLOW, ACT_TRACE: v = V_ALLOW;
            ACT_KILL, ACT_TRAP:   v = V_HALT;
            default:              v = V_DENY;
        endcase
        return v;
    endfunction

    function automatic t_result f_default_result(input logic [2:0] act);
        t_result r;
        r = '0;
        case (act)
            ACT_KILL, ACT_TRAP: begin
                r.verdict = V_HALT;
            end
            ACT_ERRNO: begin
                r.verdict     = V_DENY;
                r.errno_valid = 1'b1;
                r.errno_value = 32'd1;
            end
            ACT_LOG: begin
                r.verdict     = V_DENY;
                r.log_request = 1'b1;
            end
            default: begin
                r.verdict = V_ALLOW;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/syscall_filter_rule_table.sv -----
// Top level of the syscall filter rule table: command intake, rule cell chain and result path.
//
// Commands enter on the input channel (i_in_valid, o_in_stall) and each gives one
// result on the output channel (o_out_valid, i_out_stall). A transfer happens at a
// rising clock edge where valid is high and stall is low.
// Rules live in a chain of RULE_SLOTS cells, one rule per cell. A check sends a probe
// into the first cell; it moves one cell per cycle and picks up the first matching
// rule; the probe passes the register of every cell, then the staging register and the
// output register. The next command is taken once the result has left the staging
// register. Add and clear act at their transfer; their result passes the staging register
// and then the output register, and the next command can be taken once it has left the
// staging register.
// A finished result waits in the output register while the receiver stalls, and one
// more result can wait in the staging register behind it; new commands are then held
// off with o_in_stall. Reset empties the table and sets the default action to allow.
// The default action register is written through i_cfg_valid / o_cfg_ready / i_cfg_data;
// the user must write it only while the block is idle; the block does not enforce this.
`default_nettype none
module syscall_filter_rule_table
    import sfrt_pkg::*;
#(
    parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_op,
    input  wire logic [15:0]        i_syscall_number,
    input  wire logic [2:0]         i_rule_action,
    input  wire logic signed [31:0] i_rule_errno,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_verdict,
    output logic                    o_errno_valid,
    output logic signed [31:0]      o_errno_value,
    output logic                    o_log_request,
    output logic                    o_add_status
);

    localparam int CW = $clog2(RULE_SLOTS + 1);

    logic [2:0]    r_default_action;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_busy;
    logic          n_busy;
    logic          r_res_valid;
    logic          n_res_valid;
    t_result       r_res;
    t_result       n_res;
    logic          r_out_valid;
    logic          n_out_valid;
    t_result       r_out;
    logic          w_accept;
    logic          w_full;
    logic          w_move;
    t_wr           w_wr;
    t_probe        w_probe [RULE_SLOTS+1];
    logic [RULE_SLOTS-1:0] w_probe_valid;
    t_probe        w_exit;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy || r_res_valid;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = r_count >= CW'(RULE_SLOTS);
    assign w_move      = r_res_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        w_wr.en  = w_accept && (i_op == OP_ADD) && !w_full;
        w_wr.sys = i_syscall_number;
        w_wr.act = i_rule_action;
        w_wr.err = i_rule_errno;
    end

    always_comb begin
        w_probe[0].valid = w_accept && (i_op == OP_CHECK);
        w_probe[0].sys   = i_syscall_number;
        w_probe[0].hit   = 1'b0;
        w_probe[0].act   = ACT_ALLOW;
        w_probe[0].err   = '0;
    end

    for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
        sfrt_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_count),
            .i_wr    (w_wr),
            .i_probe (w_probe[g]),
            .o_probe (w_probe[g+1])
        );
        assign w_probe_valid[g] = w_probe[g+1].valid;
    end

    assign w_exit = w_probe[RULE_SLOTS];

    always_comb begin
        n_count     = r_count;
        n_busy      = r_busy;
        n_res_valid = r_res_valid && !w_move;
        n_res       = r_res;
        if (w_accept) begin
            n_res       = '0;
            n_res_valid = 1'b1;
            case (i_op)
                OP_CHECK: begin
                    n_busy      = 1'b1;
                    n_res_valid = 1'b0;
                end
                OP_ADD: begin
                    if (w_full) begin
                        n_res.add_status = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
        if (w_exit.valid) begin
            n_busy      = 1'b0;
            n_res_valid = 1'b1;
            if (w_exit.hit) begin
                n_res             = '0;
                n_res.verdict     = f_rule_verdict(w_exit.act);
                n_res.errno_valid = 1'b1;
                n_res.errno_value = w_exit.err;
            end else begin
                n_res = f_default_result(r_default_action);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (w_move) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_action <= ACT_ALLOW;
            r_count          <= '0;
            r_busy           <= 1'b0;
            r_res_valid      <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_default_action <= i_cfg_data;
            end
            r_count     <= n_count;
            r_busy      <= n_busy;
            r_res_valid <= n_res_valid;
            r_out_valid <= n_out_valid;
        end
        r_res <= n_res;
        if (w_move) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_verdict     = r_out.verdict;
    assign o_errno_valid = r_out.errno_valid;
    assign o_errno_value = r_out.errno_value;
    assign o_log_request = r_out.log_request;
    assign o_add_status  = r_out.add_status;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RULE_SLOTS))
        else $error("Rule count exceeds the number of slots.");

    a_one_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_probe_valid) <= 1)
        else $error("More than one probe in the rule chain.");

    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> r_busy && !r_res_valid)
        else $error("Probe left the chain with no check in flight.");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.add_status) |-> w_full)
        else $error("Table full reported while the table has room.");
`endif

endmodule
`default_nettype wire

// ----- rtl/sfrt_cell.sv -----
// One rule cell of the chain: stores one rule and matches the probe passing through it.
`default_nettype none
module sfrt_cell
    import sfrt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [CW-1:0] i_count,
    input  wire t_wr           i_wr,
    input  wire t_probe        i_probe,
    output t_probe             o_probe
);

    logic [15:0] r_sys;
    logic [2:0]  r_act;
    logic [31:0] r_err;
    logic        r_valid;
    t_probe      r_probe;
    t_probe      n_probe;
    logic        w_live;

    assign w_live = CW'(IDX) < i_count;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_count == CW'(IDX))) begin
            r_sys <= i_wr.sys;
            r_act <= i_wr.act;
            r_err <= i_wr.err;
        end
    end

    always_comb begin
        n_probe = i_probe;
        if (i_probe.valid && !i_probe.hit && w_live && (r_sys == i_probe.sys)) begin
            n_probe.hit = 1'b1;
            n_probe.act = r_act;
            n_probe.err = r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_probe.valid;
        end
        r_probe <= n_probe;
    end

    always_comb begin
        o_probe       = r_probe;
        o_probe.valid = r_valid;
    end

endmodule
`default_nettype wire
